// ===== src/hring_pkg.sv =====
// shared types and constants for the history ring with indexed read
// no dependencies; imported by hring_mod and history_ring_indexed_read
package hring_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SIZE_W = ADDR_W + 1;
  localparam int ITEM_W = 32;
  localparam int SEQ_W  = 64;
  localparam int CNT_W  = $clog2(SEQ_W + 1);

  localparam logic [1:0] MODE_PUSH      = 2'd0;
  localparam logic [1:0] MODE_PEEK      = 2'd1;
  localparam logic [1:0] MODE_RESET_CNT = 2'd2;
  localparam logic [1:0] MODE_NOP       = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ
  } state_t;

  typedef struct packed {
    logic start;
    logic short_op;
  } mod_req_t;

endpackage

// ===== src/hring_mod.sv =====
// bit-serial remainder unit: dividend mod divisor, one dividend bit per cycle
// long operation covers all SEQ_W bits, short operation only the low SIZE_W bits
// depends on hring_pkg
module hring_mod (
  input  logic                            clk,
  input  logic                            rst,
  input  hring_pkg::mod_req_t             req,
  input  logic [hring_pkg::SEQ_W-1:0]     dividend,
  input  logic [hring_pkg::SIZE_W-1:0]    divisor,
  output logic                            done,
  output logic [hring_pkg::ADDR_W-1:0]    remainder
);
  import hring_pkg::*;

  localparam int SHORT_PAD = SEQ_W - SIZE_W;

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic [SEQ_W-1:0]    shreg;
  logic [ADDR_W-1:0]   rem;
  logic [SIZE_W-1:0]   div_q;
  logic [SIZE_W-1:0]   trial;
  logic [SIZE_W-1:0]   trial_sub;
  logic                fits;

  assign trial     = {rem, shreg[SEQ_W-1]};
  assign fits      = trial >= div_q;
  assign trial_sub = trial - div_q;
  assign done      = busy && (cnt == '0);
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.short_op ? CNT_W'(SIZE_W) : CNT_W'(SEQ_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= req.short_op ? {dividend[SIZE_W-1:0], {SHORT_PAD{1'b0}}} : dividend;
      rem   <= '0;
      div_q <= divisor;
    end else if (busy && (cnt != '0)) begin
      shreg <= {shreg[SEQ_W-2:0], 1'b0};
      rem   <= fits ? trial_sub[ADDR_W-1:0] : trial[ADDR_W-1:0];
    end
  end

endmodule

// ===== src/history_ring_indexed_read.sv =====
// history ring with absolute sequence index: push, peek with fallback to newest
// push, counter reset, no-op: result via holding and output register, one transaction
// per cycle unless the output stalls; a slot wrap past one ring uses the remainder unit
// peek: a non-rejected index runs the 64-step serial remainder, then one memory read,
// then the holding and output registers; inputs stall until the read result is loaded
// reset: a pass over all 1024 slots zeroes the item memory, inputs stalled meanwhile
// depends on hring_pkg and hring_mod
module history_ring_indexed_read (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hring_pkg::SIZE_W-1:0]      buffer_size,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [hring_pkg::ITEM_W-1:0]      item_data,
  input  logic signed [hring_pkg::SEQ_W-1:0] peek_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              status,
  output logic [hring_pkg::ITEM_W-1:0]      read_data,
  output logic signed [hring_pkg::SEQ_W-1:0] index_used
);
  import hring_pkg::*;

  state_t state, state_next;

  logic [ITEM_W-1:0] mem [DEPTH];
  logic [ITEM_W-1:0] rd_data;

  logic [SIZE_W-1:0] size_cfg;
  logic [SEQ_W-1:0]  seq;
  logic [ADDR_W-1:0] write_slot;
  logic [ADDR_W-1:0] clr_addr;
  logic              pend_peek;
  logic [SEQ_W-1:0]  used_q;

  logic              res_valid;
  logic              res_status;
  logic [ITEM_W-1:0] res_data;
  logic [SEQ_W-1:0]  res_used;

  logic [SIZE_W-1:0] size_eff;
  logic [SEQ_W-1:0]  oldest;
  logic              reject;
  logic              fallback;
  logic [SEQ_W-1:0]  idx_eff;
  logic [SIZE_W-1:0] ws_inc;
  logic [SIZE_W-1:0] ws_sub;
  logic              ws_fast;
  logic [ADDR_W-1:0] ws_fast_val;

  logic              accept;
  logic              res_free;
  logic              out_take;
  logic              clr_last;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ITEM_W-1:0] mem_wdata;
  logic              mem_re;
  logic              res_load;
  logic              res_status_next;
  logic [ITEM_W-1:0] res_data_next;
  logic [SEQ_W-1:0]  res_used_next;
  mod_req_t          mod_req;
  logic [SEQ_W-1:0]  mod_dividend;
  logic              mod_done;
  logic [ADDR_W-1:0] mod_rem;

  hring_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .req       (mod_req),
    .dividend  (mod_dividend),
    .divisor   (size_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign cfg_ready = 1'b1;

  always_comb begin
    if (size_cfg == '0) begin
      size_eff = SIZE_W'(1);
    end else if (size_cfg > SIZE_RESET) begin
      size_eff = SIZE_RESET;
    end else begin
      size_eff = size_cfg;
    end
  end

  assign oldest   = seq - SEQ_W'(size_eff);
  assign reject   = peek_index >= $signed(seq);
  assign fallback = peek_index[SEQ_W-1] || (peek_index <= $signed(oldest));
  assign idx_eff  = fallback ? (seq - SEQ_W'(1)) : peek_index;

  assign ws_inc      = SIZE_W'(write_slot) + SIZE_W'(1);
  assign ws_sub      = ws_inc - size_eff;
  assign ws_fast     = (ws_inc < size_eff) || (ws_sub < size_eff);
  assign ws_fast_val = (ws_inc < size_eff) ? ws_inc[ADDR_W-1:0] : ws_sub[ADDR_W-1:0];

  assign out_take = res_valid && (!out_valid || !out_stall);
  assign res_free = !res_valid || out_take;
  assign in_stall = (state != ST_IDLE) || !res_free;
  assign accept   = in_valid && !in_stall;
  assign clr_last = clr_addr == ADDR_W'(DEPTH - 1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if ((mode == MODE_PEEK) && !reject) state_next = ST_MOD;
          if ((mode == MODE_PUSH) && !ws_fast) state_next = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) state_next = pend_peek ? ST_READ : ST_IDLE;
      end
      ST_READ: begin
        if (res_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we           = 1'b0;
    mem_waddr        = write_slot;
    mem_wdata        = item_data;
    mem_re           = 1'b0;
    res_load         = 1'b0;
    res_status_next  = 1'b0;
    res_data_next    = '0;
    res_used_next    = '0;
    mod_req.start    = 1'b0;
    mod_req.short_op = 1'b0;
    mod_dividend     = idx_eff;
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          case (mode)
            MODE_PUSH: begin
              mem_we = 1'b1;
              if (!ws_fast) begin
                mod_req.start    = 1'b1;
                mod_req.short_op = 1'b1;
                mod_dividend     = SEQ_W'(ws_inc);
              end
            end
            MODE_PEEK: begin
              if (reject) begin
                res_status_next = 1'b1;
              end else begin
                res_load      = 1'b0;
                mod_req.start = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done && pend_peek) mem_re = 1'b1;
      end
      ST_READ: begin
        if (res_free) begin
          res_load      = 1'b1;
          res_data_next = rd_data;
          res_used_next = used_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mod_rem];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      size_cfg <= buffer_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq        <= SEQ_W'(1);
      write_slot <= ADDR_W'(1);
    end else if (accept && (mode == MODE_PUSH)) begin
      seq <= seq + SEQ_W'(1);
      if (ws_fast) write_slot <= ws_fast_val;
    end else if (accept && (mode == MODE_RESET_CNT)) begin
      seq        <= SEQ_W'(1);
      write_slot <= ADDR_W'(1);
    end else if ((state == ST_MOD) && mod_done && !pend_peek) begin
      write_slot <= mod_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_peek <= mode == MODE_PEEK;
      used_q    <= idx_eff;
    end
  end

  // result holding stage ahead of the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (out_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_next;
      res_data   <= res_data_next;
      res_used   <= res_used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      status     <= res_status;
      read_data  <= res_data;
      index_used <= res_used;
    end
  end

endmodule

// ===== tb/history_ring_indexed_read_tb.sv =====
// self-checking testbench for history_ring_indexed_read: directed and random push/peek/no-op/counter-reset traffic
// with random idling on both sides, checked against a behavioral ring model in a scoreboard
// depends on hring_pkg and the history_ring_indexed_read RTL
module history_ring_indexed_read_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hring_pkg::*;

  localparam int ITEMS_PER_SEG  = 94;
  localparam int NUM_SEGS       = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 100;

  typedef struct packed {
    logic              st;
    logic [ITEM_W-1:0] data;
    logic [SEQ_W-1:0]  used;
  } ring_result_t;

  class ring_scoreboard;
    logic [ITEM_W-1:0] slots [DEPTH];
    logic [SEQ_W-1:0]  seq_count;
    int unsigned       wr_slot;
    logic [SIZE_W-1:0] size_reg;
    ring_result_t      expected_q [$];
    int                errors, checked, peeks_ok, rejects, fallbacks;

    function new();
      foreach (slots[i]) slots[i] = '0;
      seq_count = 1;
      wr_slot   = 1;
      size_reg  = SIZE_RESET;
      errors    = 0;
      checked   = 0;
      peeks_ok  = 0;
      rejects   = 0;
      fallbacks = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] v);
      size_reg = v;
    endfunction

    function int unsigned ring_size();
      if (size_reg == 0) return 1;
      if (size_reg > DEPTH) return DEPTH;
      return 32'(size_reg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_item(logic [1:0] op, logic [ITEM_W-1:0] d, logic [SEQ_W-1:0] idx_in);
      ring_result_t            r;
      int unsigned             sz;
      logic signed [SEQ_W-1:0] head, oldest, idx;
      logic [SEQ_W-1:0]        uidx;
      sz = ring_size();
      r  = '0;
      case (op)
        MODE_PUSH: begin
          if (wr_slot < DEPTH) slots[wr_slot] = d;
          wr_slot   = (wr_slot + 1) % sz;
          seq_count = seq_count + 1;
        end
        MODE_PEEK: begin
          head   = seq_count;
          oldest = seq_count - SEQ_W'(sz);
          idx    = idx_in;
          if (idx >= head) begin
            r.st = 1'b1;
            rejects++;
          end else begin
            if (idx < 0 || idx <= oldest) begin
              idx = seq_count - 1;
              fallbacks++;
            end
            uidx   = idx;
            r.data = slots[uidx % SEQ_W'(sz)];
            r.used = idx;
            peeks_ok++;
          end
        end
        MODE_RESET_CNT: begin
          seq_count = 1;
          wr_slot   = 1;
        end
        default: begin
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic st, logic [ITEM_W-1:0] d, logic [SEQ_W-1:0] used);
      ring_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no transaction pending: status %0b data %h index %0d",
                 $time, st, d, $signed(used));
        errors++;
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (st !== e.st) begin
        $display("%0t: status mismatch: expected %0b, actual %0b", $time, e.st, st);
        errors++;
      end
      if (d !== e.data) begin
        $display("%0t: read_data mismatch: expected %h, actual %h", $time, e.data, d);
        errors++;
      end
      if (used !== e.used) begin
        $display("%0t: index_used mismatch: expected %0d, actual %0d", $time,
                 $signed(e.used), $signed(used));
        errors++;
      end
    endfunction
  endclass

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     cfg_valid   = 1'b0;
  logic                     cfg_ready;
  logic [SIZE_W-1:0]        buffer_size = SIZE_RESET;
  logic                     in_valid    = 1'b0;
  logic                     in_stall;
  logic [1:0]               mode        = MODE_NOP;
  logic [ITEM_W-1:0]        item_data   = '0;
  logic signed [SEQ_W-1:0]  peek_index  = '0;
  logic                     out_valid;
  logic                     out_stall   = 1'b0;
  logic                     status;
  logic [ITEM_W-1:0]        read_data;
  logic signed [SEQ_W-1:0]  index_used;

  ring_scoreboard   sb;
  logic [SEQ_W-1:0] gen_seq = 1;
  int               tx_pct  = 33;
  int               rx_pct  = 64;
  int               n_items = 0;
  int               n_cfg   = 0;
  int               idle_cycles = 0;

  history_ring_indexed_read u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .buffer_size (buffer_size),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .item_data   (item_data),
    .peek_index  (peek_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_data   (read_data),
    .index_used  (index_used)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_item(mode, item_data, peek_index);
    if (!rst && out_valid && !out_stall) sb.check_result(status, read_data, index_used);
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(input logic [1:0] op, input logic [ITEM_W-1:0] d,
                      input logic [SEQ_W-1:0] idx);
    while ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    item_data  <= d;
    peek_index <= idx;
    do @(posedge clk); while (in_stall);
    if (op == MODE_PUSH) gen_seq = gen_seq + 1;
    else if (op == MODE_RESET_CNT) gen_seq = 1;
    n_items++;
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid   <= 1'b1;
    buffer_size <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_size(v);
    cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic send_random();
    int unsigned      r, sz;
    logic [1:0]       op;
    logic [ITEM_W-1:0] d;
    logic [SEQ_W-1:0] idx;
    r   = $urandom_range(99);
    sz  = sb.ring_size();
    d   = $urandom;
    idx = {$urandom, $urandom};
    op  = MODE_PEEK;
    if (r < 44) op = MODE_PUSH;
    else if (r < 82) idx = gen_seq + 1 - SEQ_W'($urandom_range(sz + 4));
    else if (r < 90) idx[SEQ_W-1] = 1'b1;
    else if (r < 94) op = MODE_NOP;
    else if (r < 97) op = MODE_RESET_CNT;
    send(op, d, idx);
  endtask

  initial begin
    logic [SIZE_W-1:0] seg_size [NUM_SEGS];
    seg_size = '{11'd1024, 11'd5, 11'd0, 11'd1, 11'd2047, 11'd16,
                 11'd1023, 11'd2, 11'd0, 11'd8, 11'd0, 11'd3};
    seg_size[8]  = SIZE_W'($urandom_range(64, 3));
    seg_size[10] = SIZE_W'($urandom_range(2047));
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fresh ring: unwritten slot zero, rejects, fallback to newest and counter reset
    send(MODE_PEEK, '0, 64'd0);
    send(MODE_PEEK, '0, 64'd1);
    send(MODE_PEEK, '1, -64'sd1);
    send(MODE_PEEK, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send(MODE_PEEK, '0, 64'h8000_0000_0000_0000);
    send(MODE_PUSH, 32'hFFFF_FFFF, '0);
    send(MODE_PUSH, 32'h0000_0000, '1);
    send(MODE_PUSH, 32'hA5A5_A5A5, '0);
    send(MODE_PEEK, '0, 64'd1);
    send(MODE_PEEK, '0, 64'd2);
    send(MODE_PEEK, '0, 64'd3);
    send(MODE_PEEK, '0, 64'd4);
    send(MODE_NOP, 32'hFFFF_FFFF, '1);
    send(MODE_RESET_CNT, '0, '0);
    send(MODE_PEEK, '0, 64'd1);
    send(MODE_PEEK, '0, 64'd0);
    send(MODE_PUSH, 32'h5A5A_5A5A, '0);
    send(MODE_PEEK, '0, 64'd1);

    // shrink the ring while in use, then hit the oldest boundary and overwritten slots
    write_size(11'd2);
    send(MODE_PUSH, 32'h1234_5678, '0);
    send(MODE_PUSH, 32'h8765_4321, '0);
    send(MODE_PUSH, 32'hDEAD_BEEF, '0);
    send(MODE_PEEK, '0, gen_seq - 1);
    send(MODE_PEEK, '0, gen_seq - 2);
    send(MODE_PEEK, '0, gen_seq - 4);

    for (int s = 0; s < NUM_SEGS; s++) begin
      if (s == 4) begin
        tx_pct = 64;
        rx_pct = 33;
      end
      if (s == 8) begin
        tx_pct = 0;
        rx_pct = 0;
      end
      write_size(seg_size[s]);
      repeat (ITEMS_PER_SEG) send_random();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d transactions in, %0d results checked over %0d ring size settings",
             n_items, sb.checked, n_cfg);
    $display("peeks: %0d read, %0d redirected to newest, %0d rejected",
             sb.peeks_ok, sb.fallbacks, sb.rejects);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
